>>> design/sqfs_pkg.sv
// Shared types and constants for the shortest-queue-first selector.
// No dependencies; used by every other file of the block but sqfs_ram.
`default_nettype none

package sqfs_pkg;

    localparam int FILE_SLOTS_DEF = 16;
    localparam int COUNT_MAX_DEF  = 1023;
    localparam int SLOT_W         = 4;
    localparam int SIZE_W         = 10;
    localparam int FIFO_DEPTH     = 2;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TAKE = 1'b1
    } op_t;

    // Classified command passed from front to back
    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] slot;
        logic              is_write;
        logic              in_range;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_SCAN,
        ST_TAKE_WR,
        ST_RESP
    } back_state_t;

endpackage

`default_nettype wire

>>> design/shortest_queue_first_selector_top.sv
// Top level of the shortest-queue-first selector.
// Depends on sqfs_pkg, sqfs_front, sqfs_back (and through it sqfs_ram).
//
// Usage:
//   Input channel s_*: one item is a command. s_cmd=0 adds one request to
//   the read (s_is_write=0) or write queue of slot s_file_slot; s_cmd=1
//   takes from the non-empty queue with the smallest count, the lowest
//   queue index winning ties (slot order, read before write).
//   Result channel m_*: exactly one result item per input item, in order.
//   An add reads and writes back its queue count (an add for a slot out of
//   range goes straight to the result); a take scans the 2*FILE_SLOTS counts
//   through the single RAM read port, one per cycle. The back executes one
//   item at a time, taking the next only after its result is registered.
//   A two-entry queue sits between the front and the back, so inputs keep
//   being accepted while the back is busy or a result waits on m_ready.
//   When m_ready stays low, the back holds its result in the output
//   register, finishes at most one more item and waits;
//   s_ready falls once the queue is full.
//   Reset: synchronous, aresetn low. After release the back clears the
//   count RAM before executing the first item; items may be accepted into
//   the queue meanwhile.
`default_nettype none

module shortest_queue_first_selector_top #(
    parameter int FILE_SLOTS = sqfs_pkg::FILE_SLOTS_DEF,
    parameter int COUNT_MAX  = sqfs_pkg::COUNT_MAX_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_cmd,
    input  wire logic [sqfs_pkg::SLOT_W-1:0] s_file_slot,
    input  wire logic                        s_is_write,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_selected_valid,
    output logic [sqfs_pkg::SLOT_W-1:0]      m_selected_file,
    output logic                             m_selected_write,
    output logic [sqfs_pkg::SIZE_W-1:0]      m_selected_size,
    output logic                             m_add_overflow
);

    logic           cmd_valid;
    logic           cmd_pop;
    sqfs_pkg::cmd_t cmd;

    sqfs_front #(
        .FILE_SLOTS(FILE_SLOTS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_file_slot(s_file_slot),
        .s_is_write (s_is_write),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    sqfs_back #(
        .FILE_SLOTS(FILE_SLOTS),
        .COUNT_MAX (COUNT_MAX)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_selected_valid(m_selected_valid),
        .m_selected_file (m_selected_file),
        .m_selected_write(m_selected_write),
        .m_selected_size (m_selected_size),
        .m_add_overflow  (m_add_overflow)
    );

    // back never pops an empty queue
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    // an overflow flag belongs to an add, a selection to a take
    a_ovf_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_add_overflow && m_selected_valid))
        else $error("overflow and selection in one item");

    // a selected queue was non-empty
    a_size_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_selected_valid) |-> (m_selected_size != '0))
        else $error("selected queue reported empty");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

>>> design/sqfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sqfs_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/sqfs_front.sv
// Front end: accepts input items, classifies them and holds them in a
// two-entry queue for the back end. Depends on sqfs_pkg.
`default_nettype none

module sqfs_front #(
    parameter int FILE_SLOTS = sqfs_pkg::FILE_SLOTS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_cmd,
    input  wire logic [sqfs_pkg::SLOT_W-1:0] s_file_slot,
    input  wire logic                        s_is_write,
    output logic                             cmd_valid,
    output sqfs_pkg::cmd_t                   cmd,
    input  wire logic                        cmd_pop
);

    localparam int PW = (sqfs_pkg::FIFO_DEPTH > 1) ? $clog2(sqfs_pkg::FIFO_DEPTH) : 1;
    localparam int CNTW = $clog2(sqfs_pkg::FIFO_DEPTH + 1);

    sqfs_pkg::cmd_t  entry_reg [sqfs_pkg::FIFO_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] fill_reg, fill_next;
    sqfs_pkg::cmd_t  in_cmd;
    logic            push;

    always_comb begin
        in_cmd.op       = s_cmd ? sqfs_pkg::OP_TAKE : sqfs_pkg::OP_ADD;
        in_cmd.slot     = s_file_slot;
        in_cmd.is_write = s_is_write;
        in_cmd.in_range = (32'(s_file_slot) < FILE_SLOTS);
    end

    assign s_ready   = (fill_reg != CNTW'(sqfs_pkg::FIFO_DEPTH));
    assign push      = s_valid && s_ready;
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(sqfs_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(sqfs_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, cmd_pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

>>> design/sqfs_back.sv
// Back end: executes add and take commands against the queue-count RAM and
// drives the registered result channel. Depends on sqfs_pkg and sqfs_ram.
`default_nettype none

module sqfs_back #(
    parameter int FILE_SLOTS = sqfs_pkg::FILE_SLOTS_DEF,
    parameter int COUNT_MAX  = sqfs_pkg::COUNT_MAX_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cmd_valid,
    input  wire sqfs_pkg::cmd_t              cmd,
    output logic                             cmd_pop,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_selected_valid,
    output logic [sqfs_pkg::SLOT_W-1:0]      m_selected_file,
    output logic                             m_selected_write,
    output logic [sqfs_pkg::SIZE_W-1:0]      m_selected_size,
    output logic                             m_add_overflow
);

    localparam int NQ = 2 * FILE_SLOTS;
    localparam int QW = $clog2(NQ);
    localparam int CW = $clog2(COUNT_MAX + 1);

    sqfs_pkg::back_state_t state_reg, state_next;
    logic [QW-1:0] cnt_reg, cnt_next;
    logic [QW-1:0] idx_reg, idx_next;
    logic [QW-1:0] best_idx_reg, best_idx_next;
    logic [CW-1:0] best_cnt_reg, best_cnt_next;
    logic          found_reg, found_next;
    logic          is_take_reg, is_take_next;
    logic          ovf_reg, ovf_next;
    logic          m_valid_reg, m_valid_next;

    logic          ram_we;
    logic [QW-1:0] ram_waddr, ram_raddr;
    logic [CW-1:0] ram_wdata, ram_rdata;
    logic [QW-1:0] add_idx;
    logic          load_out;

    sqfs_ram #(
        .WIDTH(CW),
        .DEPTH(NQ)
    ) u_count_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // queue index = slot*2 + direction
    assign add_idx  = QW'({cmd.slot, cmd.is_write});
    assign load_out = (state_reg == sqfs_pkg::ST_RESP) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        best_idx_next = best_idx_reg;
        best_cnt_next = best_cnt_reg;
        found_next    = found_reg;
        is_take_next  = is_take_reg;
        ovf_next      = ovf_reg;
        m_valid_next  = m_valid_reg;
        cmd_pop       = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = cnt_reg;
        ram_wdata     = '0;
        ram_raddr     = cnt_reg + 1'b1;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            sqfs_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == QW'(NQ - 1)) begin
                    cnt_next   = '0;
                    state_next = sqfs_pkg::ST_IDLE;
                end
            end
            sqfs_pkg::ST_IDLE: begin
                ram_raddr = '0;
                if (cmd_valid) begin
                    cmd_pop    = 1'b1;
                    found_next = 1'b0;
                    ovf_next   = 1'b0;
                    cnt_next   = '0;
                    if (cmd.op == sqfs_pkg::OP_TAKE) begin
                        is_take_next = 1'b1;
                        state_next   = sqfs_pkg::ST_SCAN;
                    end else begin
                        is_take_next = 1'b0;
                        idx_next     = add_idx;
                        ram_raddr    = add_idx;
                        state_next   = cmd.in_range ? sqfs_pkg::ST_ADD_RD
                                                    : sqfs_pkg::ST_RESP;
                    end
                end
            end
            sqfs_pkg::ST_ADD_RD: begin
                if (ram_rdata >= CW'(COUNT_MAX)) begin
                    ovf_next = 1'b1;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg;
                    ram_wdata = ram_rdata + 1'b1;
                end
                state_next = sqfs_pkg::ST_RESP;
            end
            sqfs_pkg::ST_SCAN: begin
                // read data belongs to queue cnt_reg; next address already issued
                if ((ram_rdata != '0) && (!found_reg || (ram_rdata < best_cnt_reg))) begin
                    found_next    = 1'b1;
                    best_idx_next = cnt_reg;
                    best_cnt_next = ram_rdata;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == QW'(NQ - 1)) begin
                    cnt_next   = '0;
                    state_next = sqfs_pkg::ST_TAKE_WR;
                end
            end
            sqfs_pkg::ST_TAKE_WR: begin
                if (found_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = best_idx_reg;
                    ram_wdata = best_cnt_reg - 1'b1;
                end
                state_next = sqfs_pkg::ST_RESP;
            end
            sqfs_pkg::ST_RESP: begin
                if (load_out) begin
                    m_valid_next = 1'b1;
                    state_next   = sqfs_pkg::ST_IDLE;
                end
            end
            default: state_next = sqfs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sqfs_pkg::ST_CLEAR;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            is_take_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            found_reg   <= found_next;
            is_take_reg <= is_take_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        best_idx_reg <= best_idx_next;
        best_cnt_reg <= best_cnt_next;
        if (load_out) begin
            if (is_take_reg && found_reg) begin
                m_selected_valid <= 1'b1;
                m_selected_file  <= sqfs_pkg::SLOT_W'(best_idx_reg >> 1);
                m_selected_write <= best_idx_reg[0];
                m_selected_size  <= sqfs_pkg::SIZE_W'(best_cnt_reg);
            end else begin
                m_selected_valid <= 1'b0;
                m_selected_file  <= '0;
                m_selected_write <= 1'b0;
                m_selected_size  <= '0;
            end
            m_add_overflow <= ovf_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

>>> tb/tb_shortest_queue_first_selector_top.sv
// Self-checking testbench for shortest_queue_first_selector_top.
// Depends on sqfs_pkg and the selector RTL; a scoreboard class tracks queue depths
// and predicts each selection, while plain tasks drive the valid/ready channels.
`timescale 1ns / 100ps

module tb_shortest_queue_first_selector_top;

    localparam int SLOT_W     = sqfs_pkg::SLOT_W;
    localparam int SIZE_W     = sqfs_pkg::SIZE_W;
    localparam int NUM_SLOTS  = sqfs_pkg::FILE_SLOTS_DEF;
    localparam int NUM_QUEUES = 2 * NUM_SLOTS;
    localparam int CNT_MAX    = sqfs_pkg::COUNT_MAX_DEF;
    localparam int HOLD_OFF   = 400;

    typedef struct packed {
        logic              sel_valid;
        logic [SLOT_W-1:0] sel_file;
        logic              sel_write;
        logic [SIZE_W-1:0] sel_size;
        logic              overflow;
    } selection_t;

    class sqf_scoreboard;
        logic [SIZE_W-1:0] depth [NUM_QUEUES];
        selection_t        expected_q [$];
        int errors;
        int compared;
        int takes;
        int empty_takes;
        int saturated_adds;

        function new();
            foreach (depth[i]) depth[i] = '0;
            errors         = 0;
            compared       = 0;
            takes          = 0;
            empty_takes    = 0;
            saturated_adds = 0;
        endfunction

        function int backlog();
            int sum;
            sum = 0;
            foreach (depth[i]) sum += depth[i];
            return sum;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // Apply one accepted command to the depth table and queue its selection.
        function void note_command(sqfs_pkg::op_t op, logic [SLOT_W-1:0] slot, logic wr);
            selection_t r;
            int idx;
            int best;
            bit found;
            r     = '0;
            best  = 0;
            found = 1'b0;
            if (op == sqfs_pkg::OP_ADD) begin
                if (slot < NUM_SLOTS) begin
                    idx = int'(slot) * 2 + int'(wr);
                    if (depth[idx] >= CNT_MAX) begin
                        r.overflow = 1'b1;
                        saturated_adds++;
                    end else begin
                        depth[idx] = depth[idx] + 1'b1;
                    end
                end
            end else begin
                takes++;
                // strict less-than: the lowest index wins a tie
                for (int q = 0; q < NUM_QUEUES; q++) begin
                    if (depth[q] != 0 && (!found || depth[q] < depth[best])) begin
                        best  = q;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    r.sel_valid = 1'b1;
                    r.sel_file  = SLOT_W'(best / 2);
                    r.sel_write = 1'(best % 2);
                    r.sel_size  = depth[best];
                    depth[best] = depth[best] - 1'b1;
                end else begin
                    empty_takes++;
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(selection_t got);
            selection_t want;
            if (expected_q.size() == 0) begin
                $error("result item with no command outstanding");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compared++;
            if (got.sel_valid !== want.sel_valid) begin
                $error("selected_valid: expected %0d, actual %0d", want.sel_valid, got.sel_valid);
                errors++;
            end
            if (got.sel_file !== want.sel_file) begin
                $error("selected_file: expected %0d, actual %0d", want.sel_file, got.sel_file);
                errors++;
            end
            if (got.sel_write !== want.sel_write) begin
                $error("selected_write: expected %0d, actual %0d", want.sel_write, got.sel_write);
                errors++;
            end
            if (got.sel_size !== want.sel_size) begin
                $error("selected_size: expected %0d, actual %0d", want.sel_size, got.sel_size);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $error("add_overflow: expected %0d, actual %0d", want.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_cmd       = 1'b0;
    logic [SLOT_W-1:0] s_file_slot = '0;
    logic              s_is_write  = 1'b0;
    logic              m_ready     = 1'b0;
    logic              s_ready;
    logic              m_valid;
    logic              m_selected_valid;
    logic [SLOT_W-1:0] m_selected_file;
    logic              m_selected_write;
    logic [SIZE_W-1:0] m_selected_size;
    logic              m_add_overflow;

    sqf_scoreboard sb = new();
    int tx_calm  = 0;
    int rx_calm  = 0;
    int sent     = 0;
    int received = 0;

    shortest_queue_first_selector_top uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_file_slot      (s_file_slot),
        .s_is_write       (s_is_write),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_selected_valid (m_selected_valid),
        .m_selected_file  (m_selected_file),
        .m_selected_write (m_selected_write),
        .m_selected_size  (m_selected_size),
        .m_add_overflow   (m_add_overflow)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Mostly back-to-back or short gaps, now and then a long one; occasional calm
    // stretches with no gaps at all.
    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 2) begin
            calm = $urandom_range(80, 30);
            return 0;
        end
        if (roll < 60) return 0;
        if (roll < 94) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic send_command(sqfs_pkg::op_t op, logic [SLOT_W-1:0] slot, logic wr);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= op;
        s_file_slot <= slot;
        s_is_write  <= wr;
        do @(posedge aclk); while (!s_ready);
        sb.note_command(op, slot, wr);
        sent++;
    endtask

    task automatic send_random_take();
        send_command(sqfs_pkg::OP_TAKE, SLOT_W'($urandom_range(NUM_SLOTS - 1)),
                     1'($urandom_range(1)));
    endtask

    // Result side: random stalls, plus one long hold-off so the input backs up.
    initial begin
        selection_t got;
        int stall;
        bit held;
        held = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!held && received == 60) begin
                stall = HOLD_OFF;
                held  = 1'b1;
            end else begin
                stall = pick_gap(rx_calm);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.sel_valid = m_selected_valid;
            got.sel_file  = m_selected_file;
            got.sel_write = m_selected_write;
            got.sel_size  = m_selected_size;
            got.overflow  = m_add_overflow;
            sb.check_result(got);
            received++;
        end
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [SLOT_W-1:0] fill_slot;
        logic              fill_wr;
        logic [SLOT_W-1:0] slot;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty take, ordering, read-before-write tie, field extremes
        send_command(sqfs_pkg::OP_TAKE, 4'hF, 1'b1);
        send_command(sqfs_pkg::OP_ADD,  4'h0, 1'b0);
        send_command(sqfs_pkg::OP_ADD,  4'hF, 1'b1);
        send_command(sqfs_pkg::OP_ADD,  4'hF, 1'b1);
        send_command(sqfs_pkg::OP_TAKE, 4'h0, 1'b0);
        send_command(sqfs_pkg::OP_TAKE, 4'hA, 1'b1);
        send_command(sqfs_pkg::OP_ADD,  4'h7, 1'b0);
        send_command(sqfs_pkg::OP_ADD,  4'h7, 1'b1);
        send_command(sqfs_pkg::OP_TAKE, 4'h5, 1'b0);
        send_command(sqfs_pkg::OP_TAKE, 4'h0, 1'b1);
        send_command(sqfs_pkg::OP_TAKE, 4'hF, 1'b0);
        send_command(sqfs_pkg::OP_TAKE, 4'h3, 1'b1);
        send_command(sqfs_pkg::OP_ADD,  4'hA, 1'b1);
        send_command(sqfs_pkg::OP_ADD,  4'h5, 1'b0);
        send_command(sqfs_pkg::OP_ADD,  4'h5, 1'b0);
        send_command(sqfs_pkg::OP_ADD,  4'hA, 1'b1);
        send_command(sqfs_pkg::OP_ADD,  4'hA, 1'b1);
        send_command(sqfs_pkg::OP_TAKE, 4'hC, 1'b1);
        send_command(sqfs_pkg::OP_TAKE, 4'h0, 1'b0);

        while (sb.backlog() > 0) send_random_take();

        // fill one queue to saturation, then push past it
        fill_slot = SLOT_W'($urandom_range(NUM_SLOTS - 1));
        fill_wr   = 1'($urandom_range(1));
        repeat (CNT_MAX + 4) send_command(sqfs_pkg::OP_ADD, fill_slot, fill_wr);
        send_random_take();
        send_command(sqfs_pkg::OP_ADD, ~fill_slot, ~fill_wr);
        send_random_take();
        send_random_take();

        // mixed traffic; half the adds land on a few hot slots to build ties
        repeat (340) begin
            if ($urandom_range(1)) begin
                if ($urandom_range(1))
                    slot = SLOT_W'($urandom_range(3));
                else
                    slot = SLOT_W'($urandom_range(NUM_SLOTS - 1));
                send_command(sqfs_pkg::OP_ADD, slot, 1'($urandom_range(1)));
            end else begin
                send_random_take();
            end
        end
        s_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (NUM_QUEUES + 16) @(posedge aclk);

        $display("Sent %0d commands and compared %0d results: %0d takes (%0d on empty queues),",
                 sent, sb.compared, sb.takes, sb.empty_takes);
        $display("%0d adds dropped at saturation, one %0d-cycle result hold-off.",
                 sb.saturated_adds, HOLD_OFF);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
